[rtl/core/tkac_pkg.sv]
package tkac_pkg;

  // Field widths of the channels and the register port
  localparam int SCORE_W     = 32;
  localparam int CLASS_OUT_W = 10;
  localparam int MISS_W      = 16;
  localparam int TOPK_W      = 4;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  // Register map
  localparam logic [CFG_AW-1:0] REG_TOP_K = 3'd0;

  localparam logic [TOPK_W-1:0] TOP_K_RESET = 4'd1;
  localparam logic [MISS_W-1:0] MISS_MAX    = 16'hFFFF;

  // Commands from the sample tracker to the top list
  typedef struct packed {
    logic insert;
    logic clear;
  } list_ctrl_t;

  // One result beat
  typedef struct packed {
    logic                   sample_missed;
    logic                   truth_found;
    logic [CLASS_OUT_W-1:0] truth_class;
    logic [MISS_W-1:0]      batch_misses;
    logic                   batch_done;
  } result_t;

endpackage

[rtl/core/tkac_in_if.sv]
interface tkac_in_if import tkac_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;
  logic                      truth_flag;
  logic                      last_class;
  logic                      last_sample;

  modport source (
    output valid, score, truth_flag, last_class, last_sample,
    input  ready
  );
  modport sink (
    input  valid, score, truth_flag, last_class, last_sample,
    output ready
  );
endinterface

[rtl/core/tkac_out_if.sv]
interface tkac_out_if import tkac_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   sample_missed;
  logic                   truth_found;
  logic [CLASS_OUT_W-1:0] truth_class;
  logic [MISS_W-1:0]      batch_misses;
  logic                   batch_done;

  modport source (
    output valid, sample_missed, truth_found, truth_class, batch_misses, batch_done,
    input  ready
  );
  modport sink (
    input  valid, sample_missed, truth_found, truth_class, batch_misses, batch_done,
    output ready
  );
endinterface

[rtl/core/top_k_accuracy_checker.sv]
// Top-k accuracy checker: class scores of a sample stream in one beat per class, in class
// order, each with a one-hot truth flag; the beat with last_class yields one result telling
// whether the truth class is among the top_k highest scores (ties rank the lower class
// first), plus the minibatch's saturating miss count, cleared after the beat with
// last_sample. A sample without a truth class is a miss. Classes at index MAX_CLASSES or
// above are ignored but may still end a sample. Scores are signed Q16.16. One beat is
// accepted every cycle: each beat is held in the input register while the parallel
// MAX_K-entry sorted list takes it; a last_class beat's result is loaded into the output
// register as it leaves. The input stalls only while a last_class beat waits for a full
// output register. Write top_k (register 0) only while the block is idle.
module top_k_accuracy_checker import tkac_pkg::*; #(
  parameter int MAX_K       = 8,
  parameter int MAX_CLASSES = 1024,
  parameter int SCORE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  tkac_in_if.sink           in_if,
  tkac_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int CLS_W  = $clog2(MAX_CLASSES);
  localparam int CNT_W  = $clog2(MAX_CLASSES + 1);
  localparam int FILL_W = $clog2(MAX_K + 1);

  logic [TOPK_W-1:0]             top_k_r;
  logic                          s1_valid_r;
  logic signed [SCORE_WIDTH-1:0] s1_score_r;
  logic                          s1_truth_r;
  logic                          s1_lc_r;
  logic                          s1_ls_r;
  logic signed [SCORE_WIDTH-1:0] score_in;
  logic [CNT_W-1:0]              cnt_r;
  logic [CLS_W-1:0]              tidx_r;
  logic                          seen_r;
  logic [MISS_W-1:0]             miss_r;
  logic                          out_free;
  logic                          s1_go;
  logic                          s1_fire;
  logic                          in_range;
  logic                          truth_upd;
  logic [CLS_W-1:0]              tidx_post;
  logic                          seen_post;
  list_ctrl_t                    list_ctrl;
  logic [CLS_W-1:0]              cls_post [MAX_K];
  logic [FILL_W-1:0]             fill_post;
  logic [MAX_K-1:0]              match;
  logic                          hit;
  logic [MISS_W-1:0]             miss_post;
  result_t                       result;

  // Register port: top_k only
  assign pready = 1'b1;
  assign prdata = (paddr == REG_TOP_K) ? CFG_DW'(top_k_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_k_r <= TOP_K_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_TOP_K)) begin
      top_k_r <= pwdata[TOPK_W-1:0];
    end
  end

  // Fit the score to the list width
  if (SCORE_WIDTH <= SCORE_W) begin : g_score_trunc
    assign score_in = in_if.score[SCORE_WIDTH-1:0];
  end else begin : g_score_ext
    assign score_in = SCORE_WIDTH'(in_if.score);
  end

  // Input register: advance unless a last beat waits on a full output register
  assign s1_go       = !s1_lc_r || out_free;
  assign s1_fire     = s1_valid_r && s1_go;
  assign in_if.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_score_r <= score_in;
      s1_truth_r <= in_if.truth_flag;
      s1_lc_r    <= in_if.last_class;
      s1_ls_r    <= in_if.last_sample;
    end
  end

  // Track the class index and the truth class of the current sample
  assign in_range  = cnt_r < CNT_W'(MAX_CLASSES);
  assign truth_upd = s1_fire && in_range && s1_truth_r;
  assign tidx_post = truth_upd ? cnt_r[CLS_W-1:0] : tidx_r;
  assign seen_post = truth_upd || seen_r;

  assign list_ctrl.insert = s1_fire && in_range;
  assign list_ctrl.clear  = s1_fire && s1_lc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      tidx_r <= '0;
      seen_r <= 1'b0;
    end else if (list_ctrl.clear) begin
      cnt_r  <= '0;
      tidx_r <= '0;
      seen_r <= 1'b0;
    end else begin
      if (list_ctrl.insert) begin
        cnt_r <= cnt_r + 1'b1;
      end
      tidx_r <= tidx_post;
      seen_r <= seen_post;
    end
  end

  tkac_topk_list #(
    .MAX_K       (MAX_K),
    .SCORE_WIDTH (SCORE_WIDTH),
    .CLS_W       (CLS_W),
    .FILL_W      (FILL_W)
  ) u_list (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (list_ctrl),
    .key       (s1_score_r),
    .cls       (cnt_r[CLS_W-1:0]),
    .cls_post  (cls_post),
    .fill_post (fill_post)
  );

  // Look for the truth class among the first top_k filled entries (always the first one)
  for (genvar i = 0; i < MAX_K; i++) begin : g_match
    assign match[i] = (32'(fill_post) > i) && ((i == 0) || (32'(top_k_r) > i)) &&
                      (cls_post[i] == tidx_post);
  end
  assign hit = seen_post && (|match);

  // Saturating miss count, dropped after the last sample of the batch
  assign miss_post = (!hit && (miss_r != MISS_MAX)) ? miss_r + 1'b1 : miss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_r <= '0;
    end else if (list_ctrl.clear) begin
      miss_r <= s1_ls_r ? '0 : miss_post;
    end
  end

  assign result.sample_missed = !hit;
  assign result.truth_found   = seen_post;
  assign result.truth_class   = seen_post ? CLASS_OUT_W'(tidx_post) : '0;
  assign result.batch_misses  = miss_post;
  assign result.batch_done    = s1_ls_r;

  tkac_out_reg u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (list_ctrl.clear),
    .data   (result),
    .free   (out_free),
    .out_if (out_if)
  );

`ifndef SYNTHESIS
  // A batch-closing result leaves the miss counter at zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (list_ctrl.clear && s1_ls_r) |=> (miss_r == '0))
    else $error("miss count not cleared after batch end");

  // A hit needs a truth class
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.sample_missed) |-> out_if.truth_found)
    else $error("hit reported without truth class");

  // A missed sample always leaves a nonzero count
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.sample_missed) |-> (out_if.batch_misses != '0))
    else $error("miss reported with zero batch count");

  // Sample state is cleared after the sample ends
  assert property (@(posedge clk) disable iff (!rst_n)
    list_ctrl.clear |=> ((cnt_r == '0) && !seen_r))
    else $error("sample state not cleared");
`endif

endmodule

[rtl/core/tkac_topk_list.sv]
module tkac_topk_list import tkac_pkg::*; #(
  parameter int MAX_K       = 8,
  parameter int SCORE_WIDTH = 32,
  parameter int CLS_W       = 10,
  parameter int FILL_W      = $clog2(MAX_K + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  list_ctrl_t                    ctrl,
  input  logic signed [SCORE_WIDTH-1:0] key,
  input  logic [CLS_W-1:0]              cls,
  output logic [CLS_W-1:0]              cls_post [MAX_K],
  output logic [FILL_W-1:0]             fill_post
);

  logic signed [SCORE_WIDTH-1:0] score_r    [MAX_K];
  logic [CLS_W-1:0]              cls_r      [MAX_K];
  logic [FILL_W-1:0]             fill_r;
  logic signed [SCORE_WIDTH-1:0] score_post [MAX_K];
  logic [MAX_K-1:0]              take;

  // Per slot: the new key lands at the first slot it beats, lower slots shift down
  for (genvar i = 0; i < MAX_K; i++) begin : g_slot
    logic signed [SCORE_WIDTH-1:0] up_score;
    logic [CLS_W-1:0]              up_cls;
    logic                          up_take;

    // Empty slots always take; ties keep the earlier class in place
    assign take[i] = (32'(fill_r) <= i) || (key > score_r[i]);

    if (i == 0) begin : g_head
      assign up_score = key;
      assign up_cls   = cls;
      assign up_take  = 1'b0;
    end else begin : g_body
      assign up_score = score_r[i-1];
      assign up_cls   = cls_r[i-1];
      assign up_take  = take[i-1];
    end

    always_comb begin
      score_post[i] = score_r[i];
      cls_post[i]   = cls_r[i];
      if (ctrl.insert && take[i]) begin
        if (up_take) begin
          score_post[i] = up_score;
          cls_post[i]   = up_cls;
        end else begin
          score_post[i] = key;
          cls_post[i]   = cls;
        end
      end
    end
  end

  // Grow the fill count until the list is full
  assign fill_post = (ctrl.insert && (fill_r != FILL_W'(MAX_K))) ? fill_r + 1'b1 : fill_r;

  // Hold list contents; entries past the fill count are never read
  always_ff @(posedge clk) begin
    score_r <= score_post;
    cls_r   <= cls_post;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (ctrl.clear) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_post;
    end
  end

endmodule

[rtl/core/tkac_out_reg.sv]
module tkac_out_reg import tkac_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  result_t    data,
  output logic       free,
  tkac_out_if.source out_if
);

  logic    valid_r;
  result_t data_r;

  // Room for a new beat when empty or when the current one leaves now
  assign free = !valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_if.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data;
    end
  end

  assign out_if.valid         = valid_r;
  assign out_if.sample_missed = data_r.sample_missed;
  assign out_if.truth_found   = data_r.truth_found;
  assign out_if.truth_class   = data_r.truth_class;
  assign out_if.batch_misses  = data_r.batch_misses;
  assign out_if.batch_done    = data_r.batch_done;

endmodule
